### rtl/rrps_pkg.sv
// shared types and constants for the round-robin priority scheduler
`timescale 1ns / 1ps

package rrps_pkg;

    localparam int NUM_SLOTS_DEF = 64;
    localparam int TOP_LEVEL_DEF = 7;
    localparam int ADDR_SLOTS    = 64;
    localparam int SLOT_IDX_W    = 6;
    localparam int PRIO_W        = 4;
    localparam int CNT_W         = 16;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [CNT_W-1:0] PERIOD_RST = 16'd100;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_SCHED = 1'b1
    } kind_t;

    typedef enum logic {
        REG_MODE   = 1'b0,
        REG_PERIOD = 1'b1
    } reg_idx_t;

    typedef enum logic {
        MODE_RR   = 1'b0,
        MODE_PRIO = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_RUNNABLE = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_DYING    = 2'd3
    } slot_status_t;

    typedef enum logic [2:0] {
        OC_GRANT   = 3'd0,
        OC_KEEP    = 3'd1,
        OC_HALT    = 3'd2,
        OC_NOLIVE  = 3'd3,
        OC_WRITTEN = 3'd4
    } outcome_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_LAST,
        FSM_COMMIT,
        FSM_RESP
    } fsm_state_t;

    typedef struct packed {
        logic              found;
        logic              cur_running;
        logic              live;
        logic [PRIO_W-1:0] best;
    } scan_res_t;

endpackage

### rtl/round_robin_priority_scheduler.sv
// top level: stream ports, scan sequencer and result register
`timescale 1ns / 1ps
// status write: after the request is accepted the result is registered from the response state
// schedule request: the scan, last, commit and response states lie between accept and result,
//   the scan reading the single-port table one slot per cycle into the compare unit
// one request at a time: the next is accepted only once the result has left the response state
// reset: all slots free, priorities and grant counter zero, mode round robin,
//   reset period 100; valid bits clear the tables in the reset cycle

module round_robin_priority_scheduler import rrps_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int TOP_LEVEL = TOP_LEVEL_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,  // slot_index[5:0], new_status[7:6], has_current[8]
    input  logic              s_tuser,  // kind[0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,  // granted_slot[5:0]
    output logic [2:0]        m_tuser,  // outcome[2:0]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int SLOT_DEPTH = (NUM_SLOTS < ADDR_SLOTS) ? NUM_SLOTS : ADDR_SLOTS;
    localparam int AW         = $clog2(SLOT_DEPTH);
    localparam logic [SLOT_IDX_W:0] DEPTH_LIM = (SLOT_IDX_W+1)'(SLOT_DEPTH);
    localparam logic [AW-1:0]       LAST_ADDR = AW'(SLOT_DEPTH - 1);

    fsm_state_t state_reg, state_next;

    mode_t             mode;
    logic [CNT_W-1:0]  reset_period;

    logic                  accept;
    kind_t                 in_kind;
    logic [SLOT_IDX_W-1:0] in_idx;
    slot_status_t          in_status;
    logic                  in_has_cur;
    logic                  in_range;
    logic [AW-1:0]         idx_a;
    logic                  cur_ok;
    logic [AW-1:0]         start_addr;

    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     cnt_reg;
    logic              cur_ok_reg;
    logic [AW-1:0]     cur_reg;
    logic              rd_vld_reg;
    logic [AW-1:0]     rd_slot_reg;
    logic [CNT_W-1:0]  count_reg;
    outcome_t          res_oc_reg;
    logic [AW-1:0]     res_slot_reg;
    logic              m_tvalid_reg;
    outcome_t          m_oc_reg;
    logic [AW-1:0]     m_slot_reg;

    logic              rd_en;
    logic              st_wr_en;
    logic              pr_clear;
    logic              pr_wr_en;
    logic              scan_start;
    logic              out_free;
    slot_status_t      rd_status;
    logic [PRIO_W-1:0] rd_prio;
    scan_res_t         scan_res;
    logic [AW-1:0]     found_slot;
    outcome_t          commit_oc;

    assign in_kind    = kind_t'(s_tuser);
    assign in_idx     = s_tdata[5:0];
    assign in_status  = slot_status_t'(s_tdata[7:6]);
    assign in_has_cur = s_tdata[8];
    assign in_range   = {1'b0, in_idx} < DEPTH_LIM;
    assign idx_a      = in_idx[AW-1:0];
    assign cur_ok     = in_has_cur && in_range;
    assign start_addr = !cur_ok ? '0 : ((idx_a == LAST_ADDR) ? '0 : idx_a + AW'(1));

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    state_next = (in_kind == KIND_WRITE) ? FSM_RESP : FSM_SCAN;
                end
            end
            FSM_SCAN: begin
                if (cnt_reg == LAST_ADDR) begin
                    state_next = FSM_LAST;
                end
            end
            FSM_LAST:   state_next = FSM_COMMIT;
            FSM_COMMIT: state_next = FSM_RESP;
            FSM_RESP: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default:    state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        rd_en      = 1'b0;
        st_wr_en   = 1'b0;
        pr_clear   = 1'b0;
        pr_wr_en   = 1'b0;
        scan_start = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_tready   = 1'b1;
                st_wr_en   = accept && (in_kind == KIND_WRITE) && in_range;
                pr_clear   = accept && (in_kind == KIND_SCHED) && (mode == MODE_PRIO)
                             && (count_reg == reset_period);
                scan_start = accept;
            end
            FSM_SCAN:   rd_en = 1'b1;
            FSM_COMMIT: pr_wr_en = (mode == MODE_PRIO) && scan_res.found;
            default:    s_tready = 1'b0;
        endcase
    end

    always_comb begin
        if (scan_res.found) begin
            commit_oc = OC_GRANT;
        end else if (scan_res.cur_running) begin
            commit_oc = OC_KEEP;
        end else if (scan_res.live) begin
            commit_oc = OC_HALT;
        end else begin
            commit_oc = OC_NOLIVE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            rd_vld_reg   <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en;
            if (pr_clear) begin
                count_reg <= '0;
            end else if (pr_wr_en) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (state_reg == FSM_RESP && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_slot_reg <= addr_reg;
        if (accept) begin
            addr_reg   <= start_addr;
            cnt_reg    <= '0;
            cur_ok_reg <= cur_ok;
            cur_reg    <= idx_a;
            res_oc_reg   <= OC_WRITTEN;
            res_slot_reg <= '0;
        end else if (state_reg == FSM_SCAN) begin
            addr_reg <= (addr_reg == LAST_ADDR) ? '0 : addr_reg + AW'(1);
            cnt_reg  <= cnt_reg + AW'(1);
        end else if (state_reg == FSM_COMMIT) begin
            res_oc_reg <= commit_oc;
            case (commit_oc)
                OC_GRANT: res_slot_reg <= found_slot;
                OC_KEEP:  res_slot_reg <= cur_reg;
                default:  res_slot_reg <= '0;
            endcase
        end
        if (state_reg == FSM_RESP && out_free) begin
            m_oc_reg   <= res_oc_reg;
            m_slot_reg <= res_slot_reg;
        end
    end

    rrps_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .mode         (mode),
        .reset_period (reset_period)
    );

    rrps_slot_table #(
        .SLOT_DEPTH (SLOT_DEPTH),
        .AW         (AW)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .st_wr_en   (st_wr_en),
        .st_wr_addr (idx_a),
        .st_wr_data (in_status),
        .pr_wr_en   (pr_wr_en),
        .pr_wr_addr (found_slot),
        .pr_wr_data (scan_res.best + PRIO_W'(1)),
        .pr_clear   (pr_clear),
        .rd_en      (rd_en),
        .rd_addr    (addr_reg),
        .rd_status  (rd_status),
        .rd_prio    (rd_prio)
    );

    rrps_scan_unit #(
        .TOP_LEVEL (TOP_LEVEL),
        .AW        (AW)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scan_start),
        .mode       (mode),
        .cur_ok     (cur_ok_reg),
        .cur_slot   (cur_reg),
        .in_vld     (rd_vld_reg),
        .in_slot    (rd_slot_reg),
        .in_status  (rd_status),
        .in_prio    (rd_prio),
        .res        (scan_res),
        .found_slot (found_slot)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_oc_reg;
    assign m_tdata  = 8'(m_slot_reg);

endmodule

### rtl/rrps_cfg_regs.sv
// apb configuration registers: mode and priority reset period
`timescale 1ns / 1ps

module rrps_cfg_regs import rrps_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output mode_t             mode,
    output logic [CNT_W-1:0]  reset_period
);

    mode_t            mode_reg;
    logic [CNT_W-1:0] period_reg;
    logic             wr_en;
    reg_idx_t         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_RR;
            period_reg <= PERIOD_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_MODE:   mode_reg   <= mode_t'(pwdata[0]);
                REG_PERIOD: period_reg <= pwdata[CNT_W-1:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_MODE:   prdata = {{(APB_DW-1){1'b0}}, mode_reg};
            REG_PERIOD: prdata = {{(APB_DW-CNT_W){1'b0}}, period_reg};
            default:    prdata = '0;
        endcase
    end

    assign mode         = mode_reg;
    assign reset_period = period_reg;

endmodule

### rtl/rrps_slot_table.sv
// slot status and priority memories with per-entry valid bits
`timescale 1ns / 1ps

module rrps_slot_table import rrps_pkg::*; #(
    parameter int SLOT_DEPTH = NUM_SLOTS_DEF,
    parameter int AW         = $clog2(SLOT_DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              st_wr_en,
    input  logic [AW-1:0]     st_wr_addr,
    input  slot_status_t      st_wr_data,
    input  logic              pr_wr_en,
    input  logic [AW-1:0]     pr_wr_addr,
    input  logic [PRIO_W-1:0] pr_wr_data,
    input  logic              pr_clear,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output slot_status_t      rd_status,
    output logic [PRIO_W-1:0] rd_prio
);

    slot_status_t      status_mem [SLOT_DEPTH];
    logic [PRIO_W-1:0] prio_mem   [SLOT_DEPTH];
    logic [SLOT_DEPTH-1:0] st_vld_reg;
    logic [SLOT_DEPTH-1:0] pr_vld_reg;
    slot_status_t      st_rd_reg;
    logic [PRIO_W-1:0] pr_rd_reg;
    logic              st_vld_rd_reg;
    logic              pr_vld_rd_reg;

    always_ff @(posedge aclk) begin
        if (st_wr_en) begin
            status_mem[st_wr_addr] <= st_wr_data;
        end
        if (pr_wr_en) begin
            prio_mem[pr_wr_addr] <= pr_wr_data;
        end
        if (rd_en) begin
            st_rd_reg <= status_mem[rd_addr];
            pr_rd_reg <= prio_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg    <= '0;
            pr_vld_reg    <= '0;
            st_vld_rd_reg <= 1'b0;
            pr_vld_rd_reg <= 1'b0;
        end else begin
            if (st_wr_en) begin
                st_vld_reg[st_wr_addr] <= 1'b1;
            end
            if (pr_clear) begin
                pr_vld_reg <= '0;
            end else if (pr_wr_en) begin
                pr_vld_reg[pr_wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                st_vld_rd_reg <= st_vld_reg[rd_addr];
                pr_vld_rd_reg <= pr_vld_reg[rd_addr];
            end
        end
    end

    assign rd_status = st_vld_rd_reg ? st_rd_reg : ST_FREE;
    assign rd_prio   = pr_vld_rd_reg ? pr_rd_reg : '0;

endmodule

### rtl/rrps_scan_unit.sv
// shared compare unit that picks the grant candidate one slot per cycle
`timescale 1ns / 1ps

module rrps_scan_unit import rrps_pkg::*; #(
    parameter int TOP_LEVEL = TOP_LEVEL_DEF,
    parameter int AW        = $clog2(NUM_SLOTS_DEF)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  mode_t             mode,
    input  logic              cur_ok,
    input  logic [AW-1:0]     cur_slot,
    input  logic              in_vld,
    input  logic [AW-1:0]     in_slot,
    input  slot_status_t      in_status,
    input  logic [PRIO_W-1:0] in_prio,
    output scan_res_t         res,
    output logic [AW-1:0]     found_slot
);

    localparam logic [PRIO_W-1:0] TOP_PRIO = PRIO_W'(TOP_LEVEL);

    scan_res_t     res_reg;
    logic [AW-1:0] fslot_reg;
    logic          cand;
    logic          take;

    assign cand = (in_status == ST_RUNNABLE) && ((mode == MODE_RR) || (in_prio <= TOP_PRIO));
    assign take = cand && (!res_reg.found || ((mode == MODE_PRIO) && (in_prio < res_reg.best)));

    always_ff @(posedge aclk) begin
        if (!aresetn || start) begin
            res_reg <= '0;
        end else if (in_vld) begin
            if (take) begin
                res_reg.found <= 1'b1;
                res_reg.best  <= in_prio;
            end
            if (in_status != ST_FREE) begin
                res_reg.live <= 1'b1;
            end
            if (cur_ok && (in_slot == cur_slot)) begin
                res_reg.cur_running <= (in_status == ST_RUNNING);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_vld && take) begin
            fslot_reg <= in_slot;
        end
    end

    assign res        = res_reg;
    assign found_slot = fslot_reg;

endmodule

### sim/tb_round_robin_priority_scheduler.sv
// self-checking testbench for the round-robin priority scheduler: stream requests vs a predictor
`timescale 1ns / 1ps

module tb_round_robin_priority_scheduler;
    import rrps_pkg::*;

    localparam int SLOTS       = NUM_SLOTS_DEF;
    localparam int TOP         = TOP_LEVEL_DEF;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        kind_t                 kind;
        logic [SLOT_IDX_W-1:0] slot;
        slot_status_t          status;
        logic                  has_cur;
    } sched_req_t;

    typedef struct {
        outcome_t              outcome;
        logic [SLOT_IDX_W-1:0] slot;
    } sched_res_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata  = '0;  // slot_index[5:0], new_status[7:6], has_current[8]
    logic              s_tuser  = 1'b0;  // kind[0]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;  // granted_slot[5:0]
    logic [2:0]        m_tuser;  // outcome[2:0]
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    round_robin_priority_scheduler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // scheduler state as the testbench sees it
    slot_status_t      status_tbl [SLOTS];
    logic [PRIO_W-1:0] prio_tbl [SLOTS];
    logic [CNT_W-1:0]  grant_cnt = '0;
    mode_t             cfg_mode = MODE_RR;
    logic [CNT_W-1:0]  cfg_period = PERIOD_RST;

    sched_req_t pending_reqs[$];
    sched_res_t pending_outcomes[$];
    int         mismatches = 0;
    logic       quiet = 1'b0;
    int         src_gap = 0;
    int         sink_stall = 0;
    int         idle_cycles = 0;

    initial begin
        foreach (status_tbl[i]) begin
            status_tbl[i] = ST_FREE;
            prio_tbl[i]   = '0;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 60);
    endfunction

    task automatic predict_scheduler(input sched_req_t rq, output sched_res_t rs);
        int   start;
        int   s;
        int   found;
        int   best;
        logic cur_ok;
        logic live;
        found  = -1;
        cur_ok = rq.has_cur && (int'(rq.slot) < SLOTS);
        rs.outcome = OC_WRITTEN;
        rs.slot    = '0;
        if (rq.kind == KIND_WRITE) begin
            if (int'(rq.slot) < SLOTS) begin
                status_tbl[rq.slot] = rq.status;
            end
            return;
        end
        start = cur_ok ? (int'(rq.slot) + 1) % SLOTS : 0;
        if (cfg_mode == MODE_RR) begin
            for (int k = 0; k < SLOTS && found < 0; k++) begin
                s = (start + k) % SLOTS;
                if (status_tbl[s] == ST_RUNNABLE) begin
                    found = s;
                end
            end
        end else begin
            if (grant_cnt == cfg_period) begin
                foreach (prio_tbl[i]) prio_tbl[i] = '0;
                grant_cnt = '0;
            end
            best = TOP + 1;
            for (int i = 0; i < SLOTS; i++) begin
                if (status_tbl[i] == ST_RUNNABLE && int'(prio_tbl[i]) <= TOP
                        && int'(prio_tbl[i]) < best) begin
                    best = int'(prio_tbl[i]);
                end
            end
            if (best <= TOP) begin
                for (int k = 0; k < SLOTS && found < 0; k++) begin
                    s = (start + k) % SLOTS;
                    if (status_tbl[s] == ST_RUNNABLE && int'(prio_tbl[s]) == best) begin
                        found = s;
                    end
                end
            end
            if (found >= 0) begin
                prio_tbl[found] = prio_tbl[found] + PRIO_W'(1);
                grant_cnt       = grant_cnt + CNT_W'(1);
            end
        end
        if (found >= 0) begin
            rs.outcome = OC_GRANT;
            rs.slot    = SLOT_IDX_W'(found);
        end else if (cur_ok && status_tbl[rq.slot] == ST_RUNNING) begin
            rs.outcome = OC_KEEP;
            rs.slot    = rq.slot;
        end else begin
            live = 1'b0;
            foreach (status_tbl[i]) begin
                if (status_tbl[i] != ST_FREE) live = 1'b1;
            end
            rs.outcome = live ? OC_HALT : OC_NOLIVE;
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        sched_req_t rq;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap != 0) begin
                s_tvalid <= 1'b0;
                src_gap  <= src_gap - 1;
            end else if (pending_reqs.size() != 0) begin
                rq = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'b0, rq.has_cur, rq.status, rq.slot};
                s_tuser  <= rq.kind;
                src_gap  <= (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            sink_stall <= 0;
        end else if (sink_stall != 0) begin
            m_tready   <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                sink_stall <= idle_len();
            end
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        sched_req_t rq;
        sched_res_t rs;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                rq.kind    = kind_t'(s_tuser);
                rq.slot    = s_tdata[5:0];
                rq.status  = slot_status_t'(s_tdata[7:6]);
                rq.has_cur = s_tdata[8];
                predict_scheduler(rq, rs);
                pending_outcomes.push_back(rs);
            end
            if (m_tvalid && m_tready) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual outcome %0d slot %0d",
                             $time, m_tuser, m_tdata[5:0]);
                    mismatches++;
                end else begin
                    rs = pending_outcomes.pop_front();
                    if (m_tuser !== rs.outcome) begin
                        $display("%0t: outcome mismatch, expected %0d, actual %0d",
                                 $time, rs.outcome, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata[5:0] !== rs.slot) begin
                        $display("%0t: granted_slot mismatch, expected %0d, actual %0d",
                                 $time, rs.slot, m_tdata[5:0]);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_req(input kind_t kind, input int slot, input slot_status_t st,
                            input logic has_cur);
        sched_req_t rq;
        rq.kind    = kind;
        rq.slot    = SLOT_IDX_W'(slot);
        rq.status  = st;
        rq.has_cur = has_cur;
        pending_reqs.push_back(rq);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || pending_outcomes.size() != 0);
    endtask

    task automatic reg_write(input reg_idx_t r, input logic [APB_DW-1:0] v);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == REG_MODE) begin
            cfg_mode = mode_t'(v[0]);
        end else begin
            cfg_period = v[CNT_W-1:0];
        end
    endtask

    task automatic queue_random(input int count);
        logic [SLOT_IDX_W-1:0] pool [8];
        int                    slot;
        int                    w;
        slot_status_t          st;
        foreach (pool[i]) pool[i] = SLOT_IDX_W'($urandom_range(0, SLOTS - 1));
        repeat (count) begin
            slot = ($urandom_range(0, 9) < 7) ? int'(pool[$urandom_range(0, 7)])
                                              : $urandom_range(0, SLOTS - 1);
            if ($urandom_range(0, 99) < 45) begin
                push_req(KIND_SCHED, slot, slot_status_t'($urandom_range(0, 3)),
                         $urandom_range(0, 9) != 0);
            end else begin
                w = $urandom_range(0, 99);
                if (w < 40) begin
                    st = ST_RUNNABLE;
                end else if (w < 60) begin
                    st = ST_RUNNING;
                end else if (w < 85) begin
                    st = ST_FREE;
                end else begin
                    st = ST_DYING;
                end
                push_req(KIND_WRITE, slot, st, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table, current slot visited last, keep, halt
        push_req(KIND_SCHED, 0, ST_FREE, 1'b0);
        push_req(KIND_SCHED, 63, ST_DYING, 1'b1);
        push_req(KIND_WRITE, 63, ST_RUNNABLE, 1'b0);
        push_req(KIND_WRITE, 0, ST_RUNNING, 1'b1);
        push_req(KIND_WRITE, 42, ST_DYING, 1'b0);
        push_req(KIND_SCHED, 63, ST_FREE, 1'b1);
        push_req(KIND_SCHED, 10, ST_FREE, 1'b1);
        push_req(KIND_WRITE, 63, ST_FREE, 1'b0);
        push_req(KIND_SCHED, 0, ST_FREE, 1'b1);
        push_req(KIND_SCHED, 0, ST_FREE, 1'b0);
        push_req(KIND_WRITE, 0, ST_FREE, 1'b0);
        push_req(KIND_WRITE, 42, ST_FREE, 1'b0);
        push_req(KIND_SCHED, 21, ST_RUNNING, 1'b1);
        wait_drained();

        // priority levels, periodic reset after every grant
        reg_write(REG_MODE, 32'(MODE_PRIO));
        reg_write(REG_PERIOD, 32'd1);
        push_req(KIND_WRITE, 1, ST_RUNNABLE, 1'b0);
        push_req(KIND_WRITE, 2, ST_RUNNABLE, 1'b0);
        push_req(KIND_WRITE, 62, ST_RUNNABLE, 1'b0);
        repeat (4) push_req(KIND_SCHED, 1, ST_FREE, 1'b1);
        wait_drained();

        // exhaust one slot past the top level
        reg_write(REG_PERIOD, 32'd65535);
        push_req(KIND_WRITE, 2, ST_FREE, 1'b0);
        push_req(KIND_WRITE, 62, ST_FREE, 1'b0);
        repeat (10) push_req(KIND_SCHED, 1, ST_FREE, 1'b1);
        push_req(KIND_WRITE, 1, ST_RUNNING, 1'b0);
        push_req(KIND_SCHED, 1, ST_FREE, 1'b1);
        push_req(KIND_WRITE, 1, ST_FREE, 1'b0);
        wait_drained();

        reg_write(REG_MODE, 32'(MODE_RR));
        queue_random(100);
        wait_drained();

        reg_write(REG_MODE, 32'(MODE_PRIO));
        reg_write(REG_PERIOD, 32'd3);
        queue_random(100);
        wait_drained();

        quiet = 1'b1;
        reg_write(REG_PERIOD, 32'd65535);
        queue_random(100);
        wait_drained();

        quiet = 1'b0;
        reg_write(REG_PERIOD, 32'd20);
        queue_random(100);
        wait_drained();

        reg_write(REG_MODE, 32'(MODE_RR));
        queue_random(100);
        wait_drained();

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
